// ===== rtl/eih_pkg.sv =====
// ----------------------------------------------------------------------------
// eih_pkg: shared types and constants of the Ethernet/IPv4 header check
// Holds the status codes, the frame byte offsets and the field structs.
// ----------------------------------------------------------------------------
package eih_pkg;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_TOO_SHORT   = 3'd1,
        ST_NOT_IPV4    = 3'd2,
        ST_BAD_VERSION = 3'd3,
        ST_BAD_HDR_LEN = 3'd4,
        ST_BAD_TOT_LEN = 3'd5
    } t_status;

    // Frame byte offsets of the captured fields.
    localparam logic [15:0] POS_ETYPE_HI = 16'd12;
    localparam logic [15:0] POS_ETYPE_LO = 16'd13;
    localparam logic [15:0] POS_VER_IHL  = 16'd14;
    localparam logic [15:0] POS_TLEN_HI  = 16'd16;
    localparam logic [15:0] POS_TLEN_LO  = 16'd17;
    localparam logic [15:0] POS_PROTO    = 16'd23;
    localparam logic [15:0] POS_SRC_FIRST = 16'd26;
    localparam logic [15:0] POS_SRC_LAST  = 16'd29;
    localparam logic [15:0] POS_DST_FIRST = 16'd30;
    localparam logic [15:0] POS_DST_LAST  = 16'd33;

    localparam logic [15:0] ETH_HDR_BYTES  = 16'd14;
    localparam logic [15:0] MIN_FRAME_LEN  = 16'd34;
    localparam logic [15:0] IP_MIN_HDR     = 16'd20;
    localparam logic [15:0] ETYPE_IPV4     = 16'h0800;
    localparam logic [3:0]  IP_VERSION_4   = 4'd4;
    localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

    typedef struct packed {
        logic [15:0] byte_count;
        logic [15:0] ether_type;
        logic [7:0]  ver_ihl;
        logic [15:0] total_length;
        logic [7:0]  proto;
        logic [31:0] src_word;
        logic [31:0] dst_word;
    } t_hdr_fields;

    typedef struct packed {
        t_status     status;
        logic [15:0] ip_length;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [7:0]  protocol;
    } t_result;

endpackage

// ===== rtl/eih_frame_if.sv =====
// ----------------------------------------------------------------------------
// eih_frame_if: frame byte channel
// Valid/ready channel that carries one frame byte and its last-byte mark.
// ----------------------------------------------------------------------------
interface eih_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;

    modport source (output valid, output frame_byte, output last_byte, input ready);
    modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

// ===== rtl/eih_result_if.sv =====
// ----------------------------------------------------------------------------
// eih_result_if: verdict channel
// Valid/ready channel that carries one frame verdict and its header fields.
// ----------------------------------------------------------------------------
interface eih_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] ip_length;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [7:0]  protocol;

    modport source (output valid, output status, output ip_length,
                    output source_address, output dest_address,
                    output protocol, input ready);
    modport sink   (input valid, input status, input ip_length,
                    input source_address, input dest_address,
                    input protocol, output ready);
endinterface

// ===== rtl/eih_capture.sv =====
// ----------------------------------------------------------------------------
// eih_capture: byte counter and header field capture
// Counts frame bytes and captures header fields; clears after the last byte.
// ----------------------------------------------------------------------------
module eih_capture (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_advance,
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    output eih_pkg::t_hdr_fields o_next
);
    import eih_pkg::*;

    t_hdr_fields r_fields;
    t_hdr_fields n_fields;

    always_comb begin
        n_fields = r_fields;
        case (r_fields.byte_count) inside
            POS_ETYPE_HI: n_fields.ether_type[15:8]   = i_byte;
            POS_ETYPE_LO: n_fields.ether_type[7:0]    = i_byte;
            POS_VER_IHL:  n_fields.ver_ihl            = i_byte;
            POS_TLEN_HI:  n_fields.total_length[15:8] = i_byte;
            POS_TLEN_LO:  n_fields.total_length[7:0]  = i_byte;
            POS_PROTO:    n_fields.proto              = i_byte;
            [POS_SRC_FIRST:POS_SRC_LAST]: begin
                n_fields.src_word = {r_fields.src_word[23:0], i_byte};
            end
            [POS_DST_FIRST:POS_DST_LAST]: begin
                n_fields.dst_word = {r_fields.dst_word[23:0], i_byte};
            end
            default: ;
        endcase
        if (r_fields.byte_count != COUNT_MAX) begin
            n_fields.byte_count = r_fields.byte_count + 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fields <= '0;
        end else if (i_advance) begin
            if (i_last) begin
                r_fields <= '0;
            end else begin
                r_fields <= n_fields;
            end
        end
    end

    assign o_next = n_fields;

endmodule

// ===== rtl/eih_verdict.sv =====
// ----------------------------------------------------------------------------
// eih_verdict: frame verdict logic
// Runs the ordered header checks and masks the fields of rejected frames.
// ----------------------------------------------------------------------------
module eih_verdict (
    input  eih_pkg::t_hdr_fields i_fields,
    output eih_pkg::t_result     o_result
);
    import eih_pkg::*;

    logic [15:0] w_avail;
    logic [15:0] w_ihl;
    t_status     w_status;

    assign w_avail = i_fields.byte_count - ETH_HDR_BYTES;
    assign w_ihl   = {10'd0, i_fields.ver_ihl[3:0], 2'b00};

    always_comb begin
        if (i_fields.byte_count < MIN_FRAME_LEN) begin
            w_status = ST_TOO_SHORT;
        end else if (i_fields.ether_type != ETYPE_IPV4) begin
            w_status = ST_NOT_IPV4;
        end else if (i_fields.ver_ihl[7:4] != IP_VERSION_4) begin
            w_status = ST_BAD_VERSION;
        end else if (w_ihl < IP_MIN_HDR || w_ihl > w_avail) begin
            w_status = ST_BAD_HDR_LEN;
        end else if (i_fields.total_length < w_ihl || i_fields.total_length > w_avail) begin
            w_status = ST_BAD_TOT_LEN;
        end else begin
            w_status = ST_OK;
        end
    end

    always_comb begin
        o_result = '0;
        o_result.status = w_status;
        if (w_status == ST_OK) begin
            o_result.ip_length      = i_fields.total_length;
            o_result.source_address = i_fields.src_word;
            o_result.dest_address   = i_fields.dst_word;
            o_result.protocol       = i_fields.proto;
        end
    end

endmodule

// ===== rtl/ethernet_ipv4_header_check.sv =====
// ----------------------------------------------------------------------------
// ethernet_ipv4_header_check: Ethernet/IPv4 header check, top level
// Takes a frame one byte per request and gives one verdict per frame.
// ----------------------------------------------------------------------------
//
//  Channel    Dir  Payload                                        Per request
//  ---------  ---  ---------------------------------------------  -----------
//  i_frame    in   frame_byte[7:0], last_byte                     one byte
//  o_result   out  status[2:0], ip_length[15:0], source_address,  one verdict
//                  dest_address[31:0], protocol[7:0]
//
//  One frame byte is taken every cycle while the input does not stall. A
//  byte waits in the input register, where the counter and capture
//  registers are updated from it. On the last byte the verdict is formed
//  from the updated state and lands in the result register at the edge
//  where that byte leaves the input register. Reset (i_rst_n low at a
//  clock edge) empties both registers and clears the capture state. Only a
//  last byte waits on the result side: it holds in the input register while
//  an earlier verdict is not yet taken, and the input then stalls; other
//  bytes never stall.
//
module ethernet_ipv4_header_check (
    input  logic   i_clk,
    input  logic   i_rst_n,
    eih_frame_if.sink    i_frame,
    eih_result_if.source o_result
);
    import eih_pkg::*;

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // Result register.
    logic    r_out_valid;
    t_result r_out;

    logic        w_advance;
    t_hdr_fields w_next;
    t_result     w_verdict;

    // The byte in the input register moves on unless it closes a frame and
    // the result register still holds a verdict that is not being taken.
    assign w_advance = r_in_valid && (!r_in_last || !r_out_valid || o_result.ready);

    assign i_frame.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_frame.ready) begin
            r_in_valid <= i_frame.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_frame.ready && i_frame.valid) begin
            r_in_byte <= i_frame.frame_byte;
            r_in_last <= i_frame.last_byte;
        end
    end

    // Counter and header capture; w_next is the state after this byte.
    eih_capture u_capture (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_byte    (r_in_byte),
        .i_last    (r_in_last),
        .o_next    (w_next)
    );

    // Ordered checks on the state that includes the last byte.
    eih_verdict u_verdict (
        .i_fields (w_next),
        .o_result (w_verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in_last) begin
            r_out <= w_verdict;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.status         = r_out.status;
    assign o_result.ip_length      = r_out.ip_length;
    assign o_result.source_address = r_out.source_address;
    assign o_result.dest_address   = r_out.dest_address;
    assign o_result.protocol       = r_out.protocol;

    // A closing byte that moves on always leaves a verdict behind it.
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in_last) |=> r_out_valid)
        else $error("closing byte produced no verdict");

    // A closing byte must not overwrite a verdict that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in_last && r_out_valid && !o_result.ready) |-> !w_advance)
        else $error("pending verdict overwritten");

    // Rejected frames carry zeroed fields.
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != ST_OK) |->
        (r_out.ip_length == 16'd0 && r_out.source_address == 32'd0 &&
         r_out.dest_address == 32'd0 && r_out.protocol == 8'd0))
        else $error("rejected frame with nonzero fields");

    // An accepted frame has at least a minimal IPv4 header.
    a_ok_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == ST_OK) |-> (r_out.ip_length >= IP_MIN_HDR))
        else $error("accepted frame with short IP length");

endmodule

// ===== sim/tb_ethernet_ipv4_header_check.sv =====
// ----------------------------------------------------------------------------
// tb_ethernet_ipv4_header_check: self-checking bench for the header check
// Streams Ethernet frames byte by byte into the block. A scoreboard tracks
// the header fields as each byte is accepted and predicts the verdict of
// every frame. Each verdict the block returns is compared with it.
// ----------------------------------------------------------------------------
module tb_ethernet_ipv4_header_check;
    import eih_pkg::*;

    // ------------------------------------------------------------------------
    // Scoreboard. It keeps its own copy of the capture state, updated from
    // every accepted byte request. A request carrying the last-byte mark
    // closes the frame, and its verdict is queued until the block returns it.
    // ------------------------------------------------------------------------
    class verdict_scoreboard;
        t_hdr_fields hdr;
        t_result     pending_verdicts[$];
        int          errors;
        int          verdicts_taken;

        function new();
            hdr            = '0;
            errors         = 0;
            verdicts_taken = 0;
        endfunction

        // Verdict of the frame whose bytes are now captured in hdr.
        function t_result frame_verdict();
            t_result     v;
            logic [15:0] hdr_len;
            logic [15:0] avail;
            v       = '0;
            hdr_len = {10'd0, hdr.ver_ihl[3:0], 2'b00};
            if (hdr.byte_count < MIN_FRAME_LEN) begin
                v.status = ST_TOO_SHORT;
            end else if (hdr.ether_type != ETYPE_IPV4) begin
                v.status = ST_NOT_IPV4;
            end else if (hdr.ver_ihl[7:4] != IP_VERSION_4) begin
                v.status = ST_BAD_VERSION;
            end else begin
                // Bytes left for the IP datagram once the MAC header is gone.
                avail = hdr.byte_count - ETH_HDR_BYTES;
                if (hdr_len < IP_MIN_HDR || hdr_len > avail) begin
                    v.status = ST_BAD_HDR_LEN;
                end else if (hdr.total_length < hdr_len || hdr.total_length > avail) begin
                    v.status = ST_BAD_TOT_LEN;
                end else begin
                    v.status         = ST_OK;
                    v.ip_length      = hdr.total_length;
                    v.source_address = hdr.src_word;
                    v.dest_address   = hdr.dst_word;
                    v.protocol       = hdr.proto;
                end
            end
            return v;
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            case (hdr.byte_count)
                POS_ETYPE_HI: hdr.ether_type[15:8]   = b;
                POS_ETYPE_LO: hdr.ether_type[7:0]    = b;
                POS_VER_IHL:  hdr.ver_ihl            = b;
                POS_TLEN_HI:  hdr.total_length[15:8] = b;
                POS_TLEN_LO:  hdr.total_length[7:0]  = b;
                POS_PROTO:    hdr.proto              = b;
                default: begin
                    if (hdr.byte_count >= POS_SRC_FIRST && hdr.byte_count <= POS_SRC_LAST) begin
                        hdr.src_word = {hdr.src_word[23:0], b};
                    end else if (hdr.byte_count >= POS_DST_FIRST &&
                                 hdr.byte_count <= POS_DST_LAST) begin
                        hdr.dst_word = {hdr.dst_word[23:0], b};
                    end
                end
            endcase
            // The count sticks at its maximum on very long frames.
            if (hdr.byte_count != COUNT_MAX) begin
                hdr.byte_count = hdr.byte_count + 16'd1;
            end
            if (last) begin
                pending_verdicts.push_back(frame_verdict());
                hdr = '0;
            end
        endfunction

        function void check_verdict(t_result got);
            t_result want;
            if (pending_verdicts.size() == 0) begin
                $error("verdict with none expected: status %0d", got.status);
                errors++;
                return;
            end
            want = pending_verdicts.pop_front();
            verdicts_taken++;
            if (got.status != want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.ip_length != want.ip_length) begin
                $error("ip_length: expected %0d, got %0d", want.ip_length, got.ip_length);
                errors++;
            end
            if (got.source_address != want.source_address) begin
                $error("source_address: expected %08h, got %08h",
                       want.source_address, got.source_address);
                errors++;
            end
            if (got.dest_address != want.dest_address) begin
                $error("dest_address: expected %08h, got %08h",
                       want.dest_address, got.dest_address);
                errors++;
            end
            if (got.protocol != want.protocol) begin
                $error("protocol: expected %0d, got %0d", want.protocol, got.protocol);
                errors++;
            end
        endfunction

        function int pending();
            return pending_verdicts.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block itself.
    // ------------------------------------------------------------------------
    logic i_clk;
    logic i_rst_n;

    eih_frame_if  frame_ch();
    eih_result_if result_ch();

    ethernet_ipv4_header_check DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_frame  (frame_ch),
        .o_result (result_ch)
    );

    verdict_scoreboard sb = new();

    // Bytes of the frame being sent, and the chance in percent that the
    // sender or the receiver starts an idle burst on a given request.
    logic [7:0] frame_q[$];
    int         send_idle_pct;
    int         recv_idle_pct;
    int         bytes_sent;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Every input of the block has a known value from time zero.
    initial begin
        i_rst_n             <= 1'b0;
        frame_ch.valid      <= 1'b0;
        frame_ch.frame_byte <= 8'h00;
        frame_ch.last_byte  <= 1'b0;
        result_ch.ready     <= 1'b0;
    end

    // Hard stop. The slowest correct run, a 64 KiB frame with the longest
    // sender gap on every byte and the receiver stalling, stays well below it.
    initial begin
        #40_000_000;
        $display("tb_ethernet_ipv4_header_check NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side. Ready drops in random bursts. Values are read right after
    // the clock edge, before any nonblocking update of that edge lands, so
    // they are the values that the edge itself sampled.
    // ------------------------------------------------------------------------
    initial begin
        t_result got;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 99) < recv_idle_pct) begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge i_clk);
            if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
                got.status         = t_status'(result_ch.status);
                got.ip_length      = result_ch.ip_length;
                got.source_address = result_ch.source_address;
                got.dest_address   = result_ch.dest_address;
                got.protocol       = result_ch.protocol;
                sb.check_verdict(got);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Frame building and sending.
    // ------------------------------------------------------------------------

    // Fills frame_q with len random bytes and lays the given header fields
    // over them. Fields that fall past the end of a short frame are lost.
    task automatic fill_frame(input int len, input logic [15:0] etype,
                              input logic [7:0] ver_ihl, input logic [15:0] total,
                              input logic [7:0] proto, input logic [31:0] src,
                              input logic [31:0] dst);
        logic [7:0] b;
        frame_q.delete();
        for (int p = 0; p < len; p++) begin
            b = 8'($urandom_range(0, 255));
            case (16'(p))
                POS_ETYPE_HI: b = etype[15:8];
                POS_ETYPE_LO: b = etype[7:0];
                POS_VER_IHL:  b = ver_ihl;
                POS_TLEN_HI:  b = total[15:8];
                POS_TLEN_LO:  b = total[7:0];
                POS_PROTO:    b = proto;
                default: begin
                    if (p >= POS_SRC_FIRST && p <= POS_SRC_LAST)
                        b = src[8 * (POS_SRC_LAST - p) +: 8];
                    else if (p >= POS_DST_FIRST && p <= POS_DST_LAST)
                        b = dst[8 * (POS_DST_LAST - p) +: 8];
                end
            endcase
            frame_q.push_back(b);
        end
    endtask

    // Random frame built to end in the given verdict. The header is well
    // formed except for the one flaw that the verdict names, so most frames
    // reach the later checks.
    task automatic make_random_frame(input t_status aim);
        int          len;
        int          avail;
        int          max_ihl;
        logic [3:0]  ihl;
        logic [3:0]  ver;
        logic [15:0] etype;
        logic [15:0] total;
        if (aim == ST_TOO_SHORT)
            len = $urandom_range(1, MIN_FRAME_LEN - 1);
        else if ($urandom_range(0, 19) == 0)
            len = $urandom_range(91, 600);
        else
            len = $urandom_range(MIN_FRAME_LEN, 90);
        avail   = len - ETH_HDR_BYTES;
        max_ihl = (avail < IP_MIN_HDR || avail / 4 > 15) ? 15 : avail / 4;
        etype   = ETYPE_IPV4;
        ver     = IP_VERSION_4;
        ihl     = 4'($urandom_range(5, max_ihl));
        total   = (avail < IP_MIN_HDR) ? 16'($urandom_range(0, 65535))
                                       : 16'($urandom_range(ihl * 4, avail));
        case (aim)
            ST_NOT_IPV4: begin
                do etype = 16'($urandom_range(0, 65535)); while (etype == ETYPE_IPV4);
            end
            ST_BAD_VERSION: begin
                do ver = 4'($urandom_range(0, 15)); while (ver == IP_VERSION_4);
            end
            ST_BAD_HDR_LEN: begin
                // Either below the minimum header or reaching past the frame.
                if (max_ihl == 15 || $urandom_range(0, 1) == 0)
                    ihl = 4'($urandom_range(0, 4));
                else
                    ihl = 4'($urandom_range(max_ihl + 1, 15));
                total = 16'($urandom_range(0, 65535));
            end
            ST_BAD_TOT_LEN: begin
                if ($urandom_range(0, 1) == 0)
                    total = 16'($urandom_range(0, ihl * 4 - 1));
                else
                    total = 16'($urandom_range(avail + 1, 65535));
            end
            default: ;
        endcase
        fill_frame(len, etype, {ver, ihl}, total, 8'($urandom_range(0, 255)),
                   $urandom, $urandom);
    endtask

    // Offers one byte request and waits until the block takes it. The
    // request counts as accepted at the edge where valid and ready were high.
    task automatic send_byte(input logic [7:0] b, input logic last);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            frame_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        frame_ch.valid      <= 1'b1;
        frame_ch.frame_byte <= b;
        frame_ch.last_byte  <= last;
        do @(posedge i_clk); while (frame_ch.ready !== 1'b1);
        sb.note_byte(b, last);
        bytes_sent++;
    endtask

    // Sends frame_q; the final byte carries the last-byte mark unless the
    // frame is left open on purpose.
    task automatic send_frame(input bit mark_end);
        for (int i = 0; i < frame_q.size(); i++)
            send_byte(frame_q[i], mark_end && (i == frame_q.size() - 1));
    endtask

    // Sender pause until every verdict owed has come back.
    task automatic wait_for_verdicts();
        frame_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        t_status aim;
        int      r;
        bytes_sent    = 0;
        send_idle_pct = 25;
        recv_idle_pct = 25;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames. A one-byte frame, and one byte short of the
        // minimum, both too short.
        fill_frame(1, 16'h0, 8'h00, 16'h0, 8'h00, 32'h0, 32'h0);
        frame_q[0] = 8'hFF;
        send_frame(1'b1);
        fill_frame(33, ETYPE_IPV4, 8'h45, 16'd19, 8'h11, 32'hC0A80001, 32'hC0A80002);
        send_frame(1'b1);
        // Smallest frame that passes, with extreme address values.
        fill_frame(34, ETYPE_IPV4, 8'h45, 16'd20, 8'hFF, 32'hFFFFFFFF, 32'h00000000);
        send_frame(1'b1);
        // Each check failing on its own in a minimal frame.
        fill_frame(34, 16'h0806, 8'h45, 16'd20, 8'h06, $urandom, $urandom);
        send_frame(1'b1);
        fill_frame(34, ETYPE_IPV4, 8'h65, 16'd20, 8'h06, $urandom, $urandom);
        send_frame(1'b1);
        fill_frame(34, ETYPE_IPV4, 8'h44, 16'd20, 8'h06, $urandom, $urandom);
        send_frame(1'b1);
        fill_frame(34, ETYPE_IPV4, 8'h46, 16'd24, 8'h06, $urandom, $urandom);
        send_frame(1'b1);
        fill_frame(34, ETYPE_IPV4, 8'h45, 16'd19, 8'h06, $urandom, $urandom);
        send_frame(1'b1);
        fill_frame(34, ETYPE_IPV4, 8'h45, 16'd21, 8'h06, $urandom, $urandom);
        send_frame(1'b1);
        // Largest header length, total length at and past the available bytes.
        fill_frame(74, ETYPE_IPV4, 8'h4F, 16'd60, 8'h00, 32'h00000000, 32'hFFFFFFFF);
        send_frame(1'b1);
        fill_frame(74, ETYPE_IPV4, 8'h4F, 16'hFFFF, 8'h00, $urandom, $urandom);
        send_frame(1'b1);
        wait_for_verdicts();

        // Very long frame: the count saturates, so the frame is judged as
        // 65535 bytes long and a total length of 65521 just fits.
        send_idle_pct = 10;
        fill_frame(int'(COUNT_MAX) + 5, ETYPE_IPV4, 8'h45, COUNT_MAX - ETH_HDR_BYTES,
                   8'h11, $urandom, $urandom);
        send_frame(1'b1);
        wait_for_verdicts();

        // Random frames, half of them valid, the rest each with one flaw.
        // Idling changes from frame to frame, including frames with none,
        // and the closing stretch of the run has no idling at all.
        while (bytes_sent < int'(COUNT_MAX) + 1650 + 300 || sb.verdicts_taken < 60) begin
            if (bytes_sent > int'(COUNT_MAX) + 1700) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else begin
                r = $urandom_range(0, 3);
                send_idle_pct = (r == 0) ? 0 : 10 * r;
                r = $urandom_range(0, 3);
                recv_idle_pct = (r == 0) ? 0 : 10 * r;
            end
            r = $urandom_range(0, 9);
            case (r)
                4:       aim = ST_TOO_SHORT;
                5:       aim = ST_NOT_IPV4;
                6:       aim = ST_BAD_VERSION;
                7:       aim = ST_BAD_HDR_LEN;
                8:       aim = ST_BAD_TOT_LEN;
                default: aim = ST_OK;
            endcase
            make_random_frame(aim);
            send_frame(1'b1);
            if ($urandom_range(0, 9) == 0)
                wait_for_verdicts();
        end

        // Drain, then keep watching the result side so that any verdict
        // that should not exist is seen.
        wait_for_verdicts();
        repeat (10) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_ethernet_ipv4_header_check OK");
        end else begin
            $display("tb_ethernet_ipv4_header_check NOT OK");
        end
        $finish;
    end

endmodule
